FILE: sv/rlcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlcg_pkg
// Shared widths, register indexes, function codes and the control structures
// that travel between the stages of the gradient sampler.
// ----------------------------------------------------------------------------
package rlcg_pkg;

   localparam int COORD_W    = 17;
   localparam int ROT_W      = 18;
   localparam int PROD_W     = 36;
   localparam int SUM_W      = 37;
   localparam int SUM_FRAC   = 32;
   localparam int INDEX_W    = 4;
   localparam int COLOR_W    = 24;
   localparam int CHAN_W     = 8;
   localparam int CHANNELS   = 3;
   localparam int COUNT_W    = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 18;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COLOR_COUNT = 2'd0,
      CSR_ROT_COS     = 2'd1,
      CSR_ROT_SIN     = 2'd2
   } csr_addr_type;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef struct packed {
      logic               valid;
      logic               func;
      logic [INDEX_W-1:0] index;
      logic [COLOR_W-1:0] color;
   } item_type;

   typedef struct packed {
      logic valid;
      logic direct;
   } mix_ctrl_type;

endpackage
`default_nettype wire

FILE: sv/rlcg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlcg_ram
// Generic RAM with one write port and two read ports, read data registered
// under a read enable.
// ----------------------------------------------------------------------------
module rlcg_ram #(
   parameter  int WIDTH  = 24,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr0,
   input  wire logic [ADDR_W-1:0] rd_addr1,
   output logic      [WIDTH-1:0]  rd_data0,
   output logic      [WIDTH-1:0]  rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data0_ff <= mem_ff[rd_addr0];
         rd_data1_ff <= mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule
`default_nettype wire

FILE: sv/rlcg_project.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlcg_project
// Projects the point onto the rotated axis: two products in the first stage,
// their sum, rescaling and clamp to the unit interval in the second.
// ----------------------------------------------------------------------------
module rlcg_project #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire rlcg_pkg::item_type                  item_i,
   input  wire logic        [rlcg_pkg::COORD_W-1:0] u_coord,
   input  wire logic        [rlcg_pkg::COORD_W-1:0] v_coord,
   input  wire logic signed [rlcg_pkg::ROT_W-1:0]   rot_cos,
   input  wire logic signed [rlcg_pkg::ROT_W-1:0]   rot_sin,
   output rlcg_pkg::item_type                       item_o,
   output logic             [FRAC_BITS:0]           alpha
);

   import rlcg_pkg::*;

   localparam int SHIFT = SUM_FRAC - FRAC_BITS;
   localparam logic [SUM_W-1:0] ONE_SUM = SUM_W'(1) << FRAC_BITS;
   localparam logic [FRAC_BITS:0] ONE_ALPHA = (FRAC_BITS+1)'(1) << FRAC_BITS;

   item_type                 item1_ff;
   item_type                 item2_ff;
   logic signed [PROD_W-1:0] prod_u_ff;
   logic signed [PROD_W-1:0] prod_v_ff;
   logic signed [SUM_W-1:0]  sum;
   logic        [SUM_W-1:0]  sum_shift;
   logic        [FRAC_BITS:0] alpha_in;
   logic        [FRAC_BITS:0] alpha_ff;

   always_comb begin
      sum       = SUM_W'(prod_u_ff) + SUM_W'(prod_v_ff);
      sum_shift = $unsigned(sum) >> SHIFT;
      priority if (sum[SUM_W-1] || (sum == '0)) begin
         alpha_in = '0;
      end else if (sum_shift > ONE_SUM) begin
         alpha_in = ONE_ALPHA;
      end else begin
         alpha_in = sum_shift[FRAC_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item1_ff.valid <= 1'b0;
         item2_ff.valid <= 1'b0;
      end else if (en) begin
         item1_ff  <= item_i;
         prod_u_ff <= $signed({1'b0, u_coord}) * rot_cos;
         prod_v_ff <= $signed({1'b0, v_coord}) * rot_sin;
         item2_ff  <= item1_ff;
         alpha_ff  <= alpha_in;
      end
   end

   assign item_o = item2_ff;
   assign alpha  = alpha_ff;

endmodule
`default_nettype wire

FILE: sv/rlcg_locate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlcg_locate
// Scales alpha by the stop count less one, then splits the product into the
// two palette addresses and the blend fraction.
// ----------------------------------------------------------------------------
module rlcg_locate #(
   parameter  int MAX_STOPS = 16,
   parameter  int FRAC_BITS = 16,
   localparam int IDX_W     = $clog2(MAX_STOPS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire rlcg_pkg::item_type     item_i,
   input  wire logic [FRAC_BITS:0]     alpha,
   input  wire logic [IDX_W-1:0]       last_index,
   output rlcg_pkg::item_type          item_o,
   output rlcg_pkg::mix_ctrl_type      ctrl_o,
   output logic      [IDX_W-1:0]       addr0,
   output logic      [IDX_W-1:0]       addr1,
   output logic      [FRAC_BITS-1:0]   blend
);

   import rlcg_pkg::*;

   localparam int P_W = FRAC_BITS + 1 + IDX_W;

   item_type             item3_ff;
   item_type             item4_ff;
   logic [P_W-1:0]       p_ff;
   logic                 zero_ff;
   logic [IDX_W:0]       idx0;
   mix_ctrl_type         ctrl_in;
   mix_ctrl_type         ctrl_ff;
   logic [IDX_W-1:0]     addr0_in;
   logic [IDX_W-1:0]     addr1_in;
   logic [IDX_W-1:0]     addr0_ff;
   logic [IDX_W-1:0]     addr1_ff;
   logic [FRAC_BITS-1:0] blend_ff;

   always_comb begin
      idx0          = p_ff[P_W-1:FRAC_BITS];
      ctrl_in.valid = item3_ff.valid && (item3_ff.func == FUNC_SAMPLE);
      priority if (zero_ff || (idx0 >= {1'b0, last_index})) begin
         ctrl_in.direct = 1'b1;
         addr0_in       = last_index;
         addr1_in       = last_index;
      end else begin
         ctrl_in.direct = 1'b0;
         addr0_in       = idx0[IDX_W-1:0];
         addr1_in       = idx0[IDX_W-1:0] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item3_ff.valid <= 1'b0;
         item4_ff.valid <= 1'b0;
         ctrl_ff.valid  <= 1'b0;
      end else if (en) begin
         item3_ff <= item_i;
         p_ff     <= P_W'(alpha * last_index);
         zero_ff  <= (alpha == '0);
         item4_ff <= item3_ff;
         ctrl_ff  <= ctrl_in;
         addr0_ff <= addr0_in;
         addr1_ff <= addr1_in;
         blend_ff <= p_ff[FRAC_BITS-1:0];
      end
   end

   assign item_o = item4_ff;
   assign ctrl_o = ctrl_ff;
   assign addr0  = addr0_ff;
   assign addr1  = addr1_ff;
   assign blend  = blend_ff;

endmodule
`default_nettype wire

FILE: sv/rlcg_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlcg_blend
// Blends the two neighbouring palette colours per channel: products of the
// fraction and the channel differences in one stage, the final subtraction
// and truncation after it.
// ----------------------------------------------------------------------------
module rlcg_blend #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire rlcg_pkg::mix_ctrl_type         ctrl_i,
   input  wire logic [FRAC_BITS-1:0]           blend,
   input  wire logic [rlcg_pkg::COLOR_W-1:0]   color0,
   input  wire logic [rlcg_pkg::COLOR_W-1:0]   color1,
   output logic                                mix_valid,
   output logic      [rlcg_pkg::COLOR_W-1:0]   mix_color
);

   import rlcg_pkg::*;

   localparam int PW = FRAC_BITS + CHAN_W + 2;

   mix_ctrl_type         ctrl5_ff;
   mix_ctrl_type         ctrl6_ff;
   logic [FRAC_BITS-1:0] blend5_ff;
   logic [COLOR_W-1:0]   c0_ff;
   logic signed [CHAN_W:0] diff [CHANNELS];
   logic signed [PW-1:0] prod_in [CHANNELS];
   logic signed [PW-1:0] prod_ff [CHANNELS];
   logic signed [PW-1:0] num [CHANNELS];
   logic [COLOR_W-1:0]   mixed;

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         diff[ch]    = $signed({1'b0, color0[ch*CHAN_W +: CHAN_W]})
                     - $signed({1'b0, color1[ch*CHAN_W +: CHAN_W]});
         prod_in[ch] = $signed({1'b0, blend5_ff}) * diff[ch];
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         num[ch] = $signed({2'b00, c0_ff[ch*CHAN_W +: CHAN_W], {FRAC_BITS{1'b0}}})
                 - prod_ff[ch];
         mixed[ch*CHAN_W +: CHAN_W] = num[ch][FRAC_BITS+CHAN_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl5_ff.valid <= 1'b0;
         ctrl6_ff.valid <= 1'b0;
      end else if (en) begin
         ctrl5_ff  <= ctrl_i;
         blend5_ff <= blend;
         ctrl6_ff  <= ctrl5_ff;
         c0_ff     <= color0;
         prod_ff   <= prod_in;
      end
   end

   assign mix_valid = ctrl6_ff.valid;
   assign mix_color = ctrl6_ff.direct ? c0_ff : mixed;

endmodule
`default_nettype wire

FILE: sv/rotated_linear_color_gradient_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_linear_color_gradient_top
// Multi-stop RGB gradient sampler along a rotated axis, with a palette
// memory loaded through the request channel.
// ----------------------------------------------------------------------------
// One request is accepted every clock cycle while req_stall is low. A
// sample request raises its colour on the response channel once it reaches
// the output register of the pipeline; a load request writes its palette
// slot and gives no response. The pipeline has seven stages: the two products,
// the clamp of alpha, the scaling by the stop count, the addressing of the
// dual-read palette memory, its registered read, the channel products, and an
// output register with a one-entry skid buffer behind it, so a stalled response
// holds the request side off only once the skid entry is full. Registers are to
// be written only while no request is in flight; the block does not enforce it.
module rotated_linear_color_gradient_top #(
   parameter int MAX_STOPS = 16,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_func,
   input  wire logic [rlcg_pkg::COORD_W-1:0]      req_u_coord,
   input  wire logic [rlcg_pkg::COORD_W-1:0]      req_v_coord,
   input  wire logic [rlcg_pkg::INDEX_W-1:0]      req_entry_index,
   input  wire logic [rlcg_pkg::COLOR_W-1:0]      req_entry_color,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [rlcg_pkg::COLOR_W-1:0]      rsp_sample_color,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rlcg_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [rlcg_pkg::CSR_DATA_W-1:0]   csr_data
);

   import rlcg_pkg::*;

   localparam int IDX_W = $clog2(MAX_STOPS);

   logic [COUNT_W-1:0]      color_count_ff;
   logic signed [ROT_W-1:0] rot_cos_ff;
   logic signed [ROT_W-1:0] rot_sin_ff;
   logic [IDX_W-1:0]        last_index_in;
   logic [IDX_W-1:0]        last_index_ff;

   logic                    adv;
   item_type                req_item;
   item_type                item2;
   item_type                item4;
   logic [FRAC_BITS:0]      alpha;
   mix_ctrl_type            ctrl4;
   logic [IDX_W-1:0]        addr0;
   logic [IDX_W-1:0]        addr1;
   logic [FRAC_BITS-1:0]    blend;
   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   logic [COLOR_W-1:0]      color0;
   logic [COLOR_W-1:0]      color1;
   logic                    mix_valid;
   logic [COLOR_W-1:0]      mix_color;

   logic                    rsp_valid_ff;
   logic [COLOR_W-1:0]      rsp_color_ff;
   logic                    skid_valid_ff;
   logic [COLOR_W-1:0]      skid_color_ff;
   logic                    take;
   logic                    fresh;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_count_ff <= COUNT_W'(1);
         rot_cos_ff     <= 18'sd65536;
         rot_sin_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_COLOR_COUNT: begin
               color_count_ff <= csr_data[COUNT_W-1:0];
            end
            CSR_ROT_COS: begin
               rot_cos_ff <= $signed(csr_data);
            end
            CSR_ROT_SIN: begin
               rot_sin_ff <= $signed(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      priority if (color_count_ff == '0) begin
         last_index_in = '0;
      end else if (32'(color_count_ff) > MAX_STOPS) begin
         last_index_in = IDX_W'(MAX_STOPS - 1);
      end else begin
         last_index_in = IDX_W'(color_count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      last_index_ff <= last_index_in;
   end

   // Pipeline.
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign req_item.valid = req_valid;
   assign req_item.func  = req_func;
   assign req_item.index = req_entry_index;
   assign req_item.color = req_entry_color;

   rlcg_project #(
      .FRAC_BITS (FRAC_BITS)
   ) u_project (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .item_i  (req_item),
      .u_coord (req_u_coord),
      .v_coord (req_v_coord),
      .rot_cos (rot_cos_ff),
      .rot_sin (rot_sin_ff),
      .item_o  (item2),
      .alpha   (alpha)
   );

   rlcg_locate #(
      .MAX_STOPS (MAX_STOPS),
      .FRAC_BITS (FRAC_BITS)
   ) u_locate (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .item_i     (item2),
      .alpha      (alpha),
      .last_index (last_index_ff),
      .item_o     (item4),
      .ctrl_o     (ctrl4),
      .addr0      (addr0),
      .addr1      (addr1),
      .blend      (blend)
   );

   assign ram_we    = adv && item4.valid && (item4.func == FUNC_LOAD);
   assign ram_waddr = IDX_W'(32'(item4.index) % MAX_STOPS);

   rlcg_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (MAX_STOPS)
   ) u_palette (
      .clock    (clock),
      .wr_en    (ram_we),
      .wr_addr  (ram_waddr),
      .wr_data  (item4.color),
      .rd_en    (adv),
      .rd_addr0 (addr0),
      .rd_addr1 (addr1),
      .rd_data0 (color0),
      .rd_data1 (color1)
   );

   rlcg_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .ctrl_i    (ctrl4),
      .blend     (blend),
      .color0    (color0),
      .color1    (color1),
      .mix_valid (mix_valid),
      .mix_color (mix_color)
   );

   // Output register with skid entry.
   assign take  = rsp_valid_ff && !rsp_stall;
   assign fresh = mix_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            rsp_color_ff  <= skid_color_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (fresh) begin
         if (!rsp_valid_ff || take) begin
            rsp_color_ff <= mix_color;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_color_ff <= mix_color;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_color = rsp_color_ff;

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("Skid entry holds a response while the output register is empty.");

   a_skid_fills_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("Skid entry filled without a stalled response.");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(mix_valid))
      else $error("Pipeline moved while the skid entry was full.");

endmodule
`default_nettype wire

FILE: bench/rotated_linear_color_gradient_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotated_linear_color_gradient_top_tb
// Self-checking bench for the rotated multi-stop gradient sampler. Palette
// loads and sample requests are driven through the request channel while an
// in-bench colour predictor keeps its own palette and register copies; every
// response is compared with the oldest predicted colour. Directed cases cover
// the single stop, zero alpha, alpha at the end and out-of-range settings,
// followed by random traffic over several register settings, a stretch with
// no idling and a long response hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module rotated_linear_color_gradient_top_tb;
   import rlcg_pkg::*;

   localparam int FRAC         = 16;
   localparam int STOPS        = 16;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 200000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_func;
   logic [COORD_W-1:0]    req_u_coord;
   logic [COORD_W-1:0]    req_v_coord;
   logic [INDEX_W-1:0]    req_entry_index;
   logic [COLOR_W-1:0]    req_entry_color;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [COLOR_W-1:0]    rsp_sample_color;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_data;

   logic [COLOR_W-1:0]    palette_model [STOPS];
   logic [COUNT_W-1:0]    model_count;
   logic signed [ROT_W-1:0] model_cos;
   logic signed [ROT_W-1:0] model_sin;

   logic [COLOR_W-1:0]    expected_colors [$];
   int                    mismatch_count;
   int                    cycle_count;
   bit                    idle_enable;
   int                    hold_requests;
   int                    hold_seen;
   int                    hold_left;
   int                    stall_left;

   rotated_linear_color_gradient_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_u_coord      (req_u_coord),
      .req_v_coord      (req_v_coord),
      .req_entry_index  (req_entry_index),
      .req_entry_color  (req_entry_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_color (rsp_sample_color),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_addr         (csr_addr),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [CHAN_W-1:0] blend_channel(logic [CHAN_W-1:0] c0,
                                                       logic [CHAN_W-1:0] c1,
                                                       longint frac);
      longint num;
      num = (longint'(c0) <<< FRAC) - frac * (longint'(c0) - longint'(c1));
      return num[FRAC+CHAN_W-1:FRAC];
   endfunction

   function automatic logic [COLOR_W-1:0] predict_color(logic [COORD_W-1:0] u,
                                                        logic [COORD_W-1:0] v);
      longint stops;
      longint proj;
      longint alpha;
      longint scaled;
      longint base;
      longint frac;
      logic [COLOR_W-1:0] c0;
      logic [COLOR_W-1:0] c1;
      stops = (model_count == 0) ? 1 : (model_count > STOPS) ? STOPS : model_count;
      if (stops == 1) return palette_model[0];
      proj = longint'(u) * longint'(model_cos) + longint'(v) * longint'(model_sin);
      alpha = (proj <= 0) ? 0 : (proj >>> (SUM_FRAC - FRAC));
      if (alpha > (longint'(1) <<< FRAC)) alpha = longint'(1) <<< FRAC;
      if (alpha == 0) return palette_model[stops-1];
      scaled = alpha * (stops - 1);
      base = scaled >>> FRAC;
      frac = scaled & ((longint'(1) <<< FRAC) - 1);
      if (base >= stops - 1) return palette_model[stops-1];
      c0 = palette_model[base];
      c1 = palette_model[base+1];
      return {blend_channel(c0[23:16], c1[23:16], frac),
              blend_channel(c0[15:8], c1[15:8], frac),
              blend_channel(c0[7:0], c1[7:0], frac)};
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      if ($urandom_range(99) < 15) return COORD_W'($urandom_range(0, 131071));
      return COORD_W'($urandom_range(0, 65536));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_rotation();
      case ($urandom_range(9))
         0: return 18'd65536;
         1: return 18'h30000;
         2: return 18'd0;
         3: return 18'h1FFFF;
         4: return 18'h20000;
         5: return CSR_DATA_W'($urandom_range(0, 18'h3FFFF));
         default: return CSR_DATA_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_count();
      case ($urandom_range(9))
         0: return 18'd0;
         1: return 18'd1;
         2: return 18'd2;
         3: return 18'd16;
         4: return CSR_DATA_W'($urandom_range(17, 31));
         default: return CSR_DATA_W'($urandom_range(2, 16));
      endcase
   endfunction

   task automatic send_request(logic func, logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                               logic [INDEX_W-1:0] slot, logic [COLOR_W-1:0] color);
      @(negedge clock);
      if (idle_enable && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_u_coord     <= u;
      req_v_coord     <= v;
      req_entry_index <= slot;
      req_entry_color <= color;
      do @(posedge clock); while (req_stall);
      if (func == FUNC_LOAD) begin
         palette_model[slot] = color;
      end else begin
         expected_colors.push_back(predict_color(u, v));
      end
   endtask

   task automatic send_random_request();
      if ($urandom_range(99) < 25) begin
         send_request(FUNC_LOAD, rand_coord(), rand_coord(),
                      INDEX_W'($urandom_range(0, 15)),
                      COLOR_W'($urandom_range(0, 24'hFFFFFF)));
      end else begin
         send_request(FUNC_SAMPLE, rand_coord(), rand_coord(),
                      INDEX_W'($urandom_range(0, 15)),
                      COLOR_W'($urandom_range(0, 24'hFFFFFF)));
      end
   endtask

   // Loads give no response, so the drain waits on past the last response to let the last load settle.
   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_addr_type addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (addr)
         CSR_COLOR_COUNT: model_count = data[COUNT_W-1:0];
         CSR_ROT_COS:     model_cos   = data;
         CSR_ROT_SIN:     model_sin   = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] count, logic [CSR_DATA_W-1:0] cosv,
                            logic [CSR_DATA_W-1:0] sinv);
      drain_requests();
      write_register(CSR_COLOR_COUNT, count);
      write_register(CSR_ROT_COS, cosv);
      write_register(CSR_ROT_SIN, sinv);
   endtask

   task automatic test_palette_fill();
      for (int i = 0; i < STOPS; i++) begin
         case (i % 4)
            0: send_request(FUNC_LOAD, '0, '0, INDEX_W'(i), 24'h000000);
            1: send_request(FUNC_LOAD, '0, '0, INDEX_W'(i), 24'hFFFFFF);
            2: send_request(FUNC_LOAD, '0, '0, INDEX_W'(i), 24'hA5C35A);
            default: send_request(FUNC_LOAD, '0, '0, INDEX_W'(i),
                                  COLOR_W'($urandom_range(0, 24'hFFFFFF)));
         endcase
      end
   endtask

   task automatic test_directed_samples();
      // Reset settings give a single stop.
      send_request(FUNC_SAMPLE, 17'd65536, 17'd0, '0, '0);
      configure(18'd16, 18'd65536, 18'd0);
      send_request(FUNC_SAMPLE, 17'd0, 17'd0, '0, '0);
      send_request(FUNC_SAMPLE, 17'd65536, 17'd0, '0, '0);
      send_request(FUNC_SAMPLE, 17'h1FFFF, 17'h1FFFF, '0, '0);
      send_request(FUNC_SAMPLE, 17'd1, 17'd0, '0, '0);
      send_request(FUNC_SAMPLE, 17'd32768, 17'd0, '0, '0);
      send_request(FUNC_SAMPLE, 17'd4369, 17'd0, '0, '0);
      configure(18'd16, 18'h30000, 18'd0);
      send_request(FUNC_SAMPLE, 17'd65536, 17'd0, '0, '0);
      configure(18'd16, 18'd0, 18'd65536);
      send_request(FUNC_SAMPLE, 17'd0, 17'd65535, '0, '0);
      configure(18'd0, 18'd65536, 18'd0);
      send_request(FUNC_SAMPLE, 17'd30000, 17'd0, '0, '0);
      configure(18'd31, 18'h1FFFF, 18'h20000);
      send_request(FUNC_SAMPLE, 17'd65536, 17'd32768, '0, '0);
      configure(18'd2, 18'd65536, 18'd0);
      send_request(FUNC_LOAD, '0, '0, 4'd0, 24'h10F0FF);
      send_request(FUNC_SAMPLE, 17'd32768, 17'd0, '0, '0);
      send_request(FUNC_SAMPLE, 17'd65535, 17'd0, '0, '0);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 5; phase++) begin
         configure(rand_count(), rand_rotation(), rand_rotation());
         repeat (200) send_random_request();
      end
   endtask

   task automatic test_no_idle();
      configure(18'd16, CSR_DATA_W'($urandom_range(0, 65536)),
                CSR_DATA_W'($urandom_range(0, 65536)));
      idle_enable = 1'b0;
      repeat (100) send_random_request();
      idle_enable = 1'b1;
   endtask

   task automatic test_backpressure();
      configure(CSR_DATA_W'($urandom_range(2, 16)), 18'd65536,
                CSR_DATA_W'($urandom_range(0, 65536)));
      hold_requests++;
      repeat (80) send_random_request();
   endtask

   always @(negedge clock) begin
      logic hold;
      hold = 1'b0;
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         hold = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         hold = 1'b1;
      end else if (idle_enable && $urandom_range(99) < 11) begin
         stall_left = $urandom_range(0, 3);
         hold = 1'b1;
      end
      rsp_stall <= hold;
   end

   always @(posedge clock) begin
      logic [COLOR_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            $error("sample_color: expected none, actual %06h", rsp_sample_color);
            mismatch_count++;
         end else begin
            want = expected_colors.pop_front();
            if (rsp_sample_color !== want) begin
               $error("sample_color: expected %06h, actual %06h", want, rsp_sample_color);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_LOAD;
      req_u_coord     = '0;
      req_v_coord     = '0;
      req_entry_index = '0;
      req_entry_color = '0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_addr        = CSR_COLOR_COUNT;
      csr_data        = '0;
      mismatch_count  = 0;
      cycle_count     = 0;
      idle_enable     = 1'b1;
      hold_requests   = 0;
      hold_seen       = 0;
      hold_left       = 0;
      stall_left      = 0;
      model_count     = 5'd1;
      model_cos       = 18'sd65536;
      model_sin       = 18'sd0;
      for (int i = 0; i < STOPS; i++) palette_model[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_palette_fill();
      test_directed_samples();
      test_random_traffic();
      test_no_idle();
      test_backpressure();

      drain_requests();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
